[rtl/core/lkpq_pkg.sv]
// Shared types and constants for the length keyed priority queue.
// Used by length_keyed_priority_queue and its testbench; depends on nothing.
package lkpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_KEY     = 19;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KEY_W       = 5;
  localparam int unsigned PAYLOAD_W   = 64;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef struct packed {
    logic                 kind;
    logic [KEY_W-1:0]     entry_key;
    logic [PAYLOAD_W-1:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [KEY_W-1:0]     popped_key;
    logic [PAYLOAD_W-1:0] popped_payload;
    logic [4:0]           fill_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } slot_t;

endpackage

[rtl/core/lkpq_slot_ram.sv]
// Simple dual-port slot store: one write port, one read port with registered data.
// Generic; depends on no package.
module lkpq_slot_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 69,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered: it appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/length_keyed_priority_queue.sv]
// Top level of the length keyed priority queue: sequencer, fill count and result register.
// Depends on lkpq_pkg and instantiates lkpq_slot_ram.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//
// A push walks down from the top of the queue, reading one slot and then comparing
// its key, and moves up each stored entry with a key equal to or above the new key
// before it writes the new entry below them; a pop reads the top slot and then takes
// it, and a rejected or failed transaction goes straight to the result step. The walk
// is set by the single read port of the slot store and the one shared key comparator.
// Reset clears the fill count, the sequencer and the result valid flag; the slot
// store is not cleared, since only slots below the fill count are ever read.
// A stalled result waits in the output register while the block is idle, so the
// next input transaction is taken regardless; the sequencer only holds its final
// step when a new result is ready and the old one has still not been taken.
module length_keyed_priority_queue
  import lkpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_RD,
    S_POP_CMP,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     idx_q;
  slot_t                new_q;
  status_e              res_status_q;
  logic [KEY_W-1:0]     res_key_q;
  logic [PAYLOAD_W-1:0] res_payload_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  logic [CNT_W-1:0]     idx_m1;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  slot_t                ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  slot_t                rd_slot;
  logic                 key_ge;
  logic [KEY_W-1:0]     key_sat;
  logic                 out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Keys above the largest legal length are clipped before they are stored.
  assign key_sat = (in_data_i.entry_key > KEY_W'(MAX_KEY)) ? KEY_W'(MAX_KEY)
                                                           : in_data_i.entry_key;

  assign idx_m1 = idx_q - CNT_W'(1);

  // The one shared comparator. The queue is sorted ascending from slot 0, so the
  // entries with a key at or above the new one sit together at the top, and
  // walking down from the top moves exactly those one slot up.
  assign key_ge = (rd_slot.key >= new_q.key);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[ADDR_W-1:0];
    ram_wdata = new_q;
    ram_raddr = idx_m1[ADDR_W-1:0];
    unique case (state_q)
      S_PUSH_RD: begin
        // At the bottom of the queue the new entry lands in slot 0.
        ram_we = (idx_q == '0);
      end
      S_PUSH_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = key_ge ? rd_slot : new_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lkpq_slot_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  ($bits(slot_t)),
    .ADDR_W (ADDR_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_slot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      new_q         <= '0;
      res_status_q  <= ST_OK;
      res_key_q     <= '0;
      res_payload_q <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // A new result is loaded whenever the output register is free; otherwise a
      // taken result simply leaves it.
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_key_q     <= '0;
            res_payload_q <= '0;
            res_status_q  <= ST_OK;
            idx_q         <= count_q;
            new_q.key     <= key_sat;
            new_q.payload <= in_data_i.entry_payload;
            if (in_data_i.kind == KIND_POP) begin
              if (count_q == '0) begin
                res_status_q <= ST_EMPTY;
                state_q      <= S_RESP;
              end else begin
                state_q <= S_POP_RD;
              end
            end else begin
              priority if (in_data_i.entry_key == '0) begin
                res_status_q <= ST_ZERO;
                state_q      <= S_RESP;
              end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_status_q <= ST_FULL;
                state_q      <= S_RESP;
              end else begin
                state_q <= S_PUSH_RD;
              end
            end
          end
        end
        S_PUSH_RD: begin
          if (idx_q == '0) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_RESP;
          end else begin
            state_q <= S_PUSH_CMP;
          end
        end
        S_PUSH_CMP: begin
          if (key_ge) begin
            idx_q   <= idx_m1;
            state_q <= S_PUSH_RD;
          end else begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_RESP;
          end
        end
        S_POP_RD: begin
          state_q <= S_POP_CMP;
        end
        S_POP_CMP: begin
          res_key_q     <= rd_slot.key;
          res_payload_q <= rd_slot.payload;
          count_q       <= idx_m1;
          state_q       <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_q.status         <= res_status_q;
            out_q.popped_key     <= res_key_q;
            out_q.popped_payload <= res_payload_q;
            out_q.fill_count     <= 5'(count_q);
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // The slot store is only written while a push is being inserted.
  a_write_in_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_PUSH_RD || state_q == S_PUSH_CMP))
    else $error("slot store written outside a push");

  // A failed or rejected transaction never reports a removed entry.
  a_fail_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.popped_key == '0 && out_data_o.popped_payload == '0))
    else $error("failed transaction carries an entry");

  // A popped key is always a stored, clipped key.
  a_popped_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.popped_key <= KEY_W'(MAX_KEY)))
    else $error("popped key above the largest key");

  // A completed pop lowers the fill count by exactly one.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_CMP) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not lower the fill count by one");

endmodule
